### hw/rtl/e2rm_pkg.sv
package e2rm_pkg;

   localparam int ANGLE_W = 16;
   localparam int TRIG_W = 16;
   localparam int CORDIC_W = 34;
   localparam int ATAN_ENTRIES = 24;
   localparam int PROD_W = 48;

   localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;
   localparam logic signed [ANGLE_W:0] PI_Q13 = 17'sd25736;
   localparam logic signed [CORDIC_W-1:0] INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [TRIG_W-1:0] ONE_Q14 = 16'sd16384;

   // arctangent of 2^-i, 30 fraction bits
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input logic [4:0] i);
      logic signed [CORDIC_W-1:0] r;
      case (i)
         5'd0: r = 34'sd843314857;
         5'd1: r = 34'sd497837829;
         5'd2: r = 34'sd263043837;
         5'd3: r = 34'sd133525159;
         5'd4: r = 34'sd67021687;
         5'd5: r = 34'sd33543516;
         5'd6: r = 34'sd16775851;
         5'd7: r = 34'sd8388437;
         5'd8: r = 34'sd4194283;
         5'd9: r = 34'sd2097149;
         default: r = CORDIC_W'(64'sd1 <<< (30 - i));
      endcase
      return r;
   endfunction

   // clamp to [-1, 1] in Q1.14
   function automatic logic signed [TRIG_W-1:0] sat_q14(input logic signed [CORDIC_W-1:0] v);
      logic signed [TRIG_W-1:0] r;
      if (v > CORDIC_W'(ONE_Q14)) r = ONE_Q14;
      else if (v < -CORDIC_W'(ONE_Q14)) r = -ONE_Q14;
      else r = v[TRIG_W-1:0];
      return r;
   endfunction

   // round Q42 sum to Q14 and clamp
   function automatic logic signed [TRIG_W-1:0] fin(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] s;
      logic signed [PROD_W-1:0] r;
      logic signed [TRIG_W-1:0] o;
      s = v + PROD_W'(64'sd134217728);
      r = s >>> 28;
      if (r > PROD_W'(ONE_Q14)) o = ONE_Q14;
      else if (r < -PROD_W'(ONE_Q14)) o = -ONE_Q14;
      else o = r[TRIG_W-1:0];
      return o;
   endfunction

   typedef struct packed {
      logic signed [TRIG_W-1:0] sn;
      logic signed [TRIG_W-1:0] cs;
   } trig_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } rot_type;

endpackage

### hw/rtl/euler_to_rotation_matrix_top.sv
// Euler angles (heading, attitude, bank; Q2.13 radians) to a 3x3 rotation
// basis (Q1.14) for one sensor a transaction. Fully pipelined: one
// transaction per cycle. Stage 0 captures the item and reduces the angles,
// then come the unrolled CORDIC stage chain (one micro-rotation per stage),
// rounding, two multiply stages and a final sum/round stage.
// Items whose sensor index is not below min(sensor count, MAX_SENSORS)
// give valid_res = 0 and all entries 0. rsp_tready low stalls the whole pipe.
module euler_to_rotation_matrix_top
   import e2rm_pkg::*;
#(
   parameter int MAX_SENSORS = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [4:0]   csr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [3:0] sensor_index, [19:4] angle_heading, [35:20] angle_attitude,
   // [51:36] angle_bank, [55:52] zero
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] valid_res, [16:1] m00, [32:17] m01, [48:33] m02, [64:49] m10,
   // [80:65] m11, [96:81] m12, [112:97] m20, [128:113] m21, [144:129] m22,
   // [151:145] zero
   output logic [151:0] rsp_tdata
);

   localparam int NS = CORDIC_STEPS;
   localparam int LAT = NS + 5;

   logic [4:0] count_ff;
   logic       adv;
   logic [LAT-1:0] vld_ff;

   assign csr_ready = 1'b1;
   assign adv = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else if (csr_valid) count_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
   end

   // stage 0: capture, valid check, quadrant reduction
   logic ok_ff [NS+4];
   logic [2:0] flip_ff [NS+1];
   rot_type rot_ff [NS+1][3];

   logic [8:0] lim;
   assign lim = (count_ff < 5'(MAX_SENSORS > 31 ? 31 : MAX_SENSORS)) ? 9'(count_ff)
              : 9'(MAX_SENSORS > 31 ? 31 : MAX_SENSORS);

   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff[0] <= 9'(req_tdata[3:0]) < lim;
         for (int k = 0; k < 3; k++) begin
            logic signed [ANGLE_W:0] a;
            logic f;
            a = 17'(signed'(req_tdata[4+16*k +: 16]));
            f = 1'b0;
            if (a > 17'(HALF_PI_Q13)) begin
               a = a - PI_Q13;
               f = 1'b1;
            end else if (a < -17'(HALF_PI_Q13)) begin
               a = a + PI_Q13;
               f = 1'b1;
            end
            flip_ff[0][k] <= f;
            rot_ff[0][k].x <= INV_GAIN_Q30;
            rot_ff[0][k].y <= '0;
            rot_ff[0][k].z <= CORDIC_W'(a) <<< 17;
         end
      end
   end

   // CORDIC stages, one micro-rotation each
   for (genvar s = 0; s < NS; s++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (adv) begin
            ok_ff[s+1] <= ok_ff[s];
            flip_ff[s+1] <= flip_ff[s];
            for (int k = 0; k < 3; k++) begin
               rot_type r;
               r = rot_ff[s][k];
               if (!r.z[CORDIC_W-1]) begin
                  rot_ff[s+1][k].x <= r.x - (r.y >>> s);
                  rot_ff[s+1][k].y <= r.y + (r.x >>> s);
                  rot_ff[s+1][k].z <= r.z - atan_q30(5'(s));
               end else begin
                  rot_ff[s+1][k].x <= r.x + (r.y >>> s);
                  rot_ff[s+1][k].y <= r.y - (r.x >>> s);
                  rot_ff[s+1][k].z <= r.z + atan_q30(5'(s));
               end
            end
         end
      end
   end

   // round to Q1.14, saturate, undo reduction
   trig_type tr_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff[NS+1] <= ok_ff[NS];
         for (int k = 0; k < 3; k++) begin
            logic signed [TRIG_W-1:0] sn, cs;
            sn = sat_q14((rot_ff[NS][k].y + CORDIC_W'(32768)) >>> 16);
            cs = sat_q14((rot_ff[NS][k].x + CORDIC_W'(32768)) >>> 16);
            tr_ff[k].sn <= flip_ff[NS][k] ? -sn : sn;
            tr_ff[k].cs <= flip_ff[NS][k] ? -cs : cs;
         end
      end
   end

   // first products (Q28)
   logic signed [31:0] chsa_ff, shsa_ff, shsb_ff, chca_ff, cacb_ff, casb_ff;
   logic signed [31:0] shca_ff, chsb_ff, shcb_ff, chcb_ff;
   logic signed [15:0] sb1_ff, cb1_ff, sa1_ff, sa2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff[NS+2] <= ok_ff[NS+1];
         chsa_ff <= tr_ff[0].cs * tr_ff[1].sn;
         shsa_ff <= tr_ff[0].sn * tr_ff[1].sn;
         shsb_ff <= tr_ff[0].sn * tr_ff[2].sn;
         chca_ff <= tr_ff[0].cs * tr_ff[1].cs;
         cacb_ff <= tr_ff[1].cs * tr_ff[2].cs;
         casb_ff <= tr_ff[1].cs * tr_ff[2].sn;
         shca_ff <= tr_ff[0].sn * tr_ff[1].cs;
         chsb_ff <= tr_ff[0].cs * tr_ff[2].sn;
         shcb_ff <= tr_ff[0].sn * tr_ff[2].cs;
         chcb_ff <= tr_ff[0].cs * tr_ff[2].cs;
         sb1_ff <= tr_ff[2].sn;
         cb1_ff <= tr_ff[2].cs;
         sa1_ff <= tr_ff[1].sn;
      end
   end

   // triple products (Q42) and two-factor terms shifted to Q42
   logic signed [PROD_W-1:0] t_ff [9];
   logic signed [PROD_W-1:0] u_ff [4];
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff[NS+3] <= ok_ff[NS+2];
         sa2_ff <= sa1_ff;
         t_ff[0] <= PROD_W'(chca_ff) <<< 14;
         t_ff[1] <= PROD_W'(shsb_ff) <<< 14;
         u_ff[0] <= PROD_W'(chsa_ff) * cb1_ff;
         u_ff[1] <= PROD_W'(chsa_ff) * sb1_ff;
         t_ff[2] <= PROD_W'(shcb_ff) <<< 14;
         t_ff[4] <= PROD_W'(cacb_ff) <<< 14;
         t_ff[5] <= -(PROD_W'(casb_ff) <<< 14);
         t_ff[6] <= -(PROD_W'(shca_ff) <<< 14);
         u_ff[2] <= PROD_W'(shsa_ff) * cb1_ff;
         t_ff[7] <= PROD_W'(chsb_ff) <<< 14;
         u_ff[3] <= PROD_W'(shsa_ff) * sb1_ff;
         t_ff[8] <= PROD_W'(chcb_ff) <<< 14;
         t_ff[3] <= '0;
      end
   end

   // sums and rounding; invalid items are masked in the output logic below
   logic signed [TRIG_W-1:0] m_ff [9];
   logic ok_out_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_out_ff <= ok_ff[NS+3];
         m_ff[0] <= fin(t_ff[0]);
         m_ff[1] <= fin(t_ff[1] - u_ff[0]);
         m_ff[2] <= fin(u_ff[1] + t_ff[2]);
         m_ff[3] <= sa2_ff;
         m_ff[4] <= fin(t_ff[4]);
         m_ff[5] <= fin(t_ff[5]);
         m_ff[6] <= fin(t_ff[6]);
         m_ff[7] <= fin(u_ff[2] + t_ff[7]);
         m_ff[8] <= fin(t_ff[8] - u_ff[3] + t_ff[3]);
      end
   end

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0] = ok_out_ff;
      for (int j = 0; j < 9; j++)
         rsp_tdata[1+16*j +: 16] = ok_out_ff ? m_ff[j] : '0;
   end

endmodule
